FILE: hw/rtl/lfv_pkg.sv
// Shared constants, types and the CRC-32 byte update for the log frame validator.
package lfv_pkg;

  // Frame header layout, in byte offsets from the start of the header.
  localparam int HDR_BYTES = 28;
  localparam int CRC_SPAN  = 24;
  localparam int LEN_BYTES = 4;
  localparam int OFF_TYPE  = 12;
  localparam int OFF_TIME  = 16;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Result queue sizing.
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = RES_PTR_W + 1;

  typedef logic [4:0] hdr_idx_t;

  typedef enum logic [1:0] {
    VERDICT_OK    = 2'd0,
    VERDICT_TRUNC = 2'd1,
    VERDICT_CRC   = 2'd2,
    VERDICT_SEQ   = 2'd3
  } verdict_t;

  typedef enum logic {
    KIND_FRAME   = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [63:0]        seq_number;
    logic [15:0]        event_type;
    logic [15:0]        schema_version;
    logic signed [63:0] time_ms;
    logic [31:0]        payload_length;
    verdict_t           verdict;
    logic [63:0]        last_good_seq;
    logic               final_item;
  } result_t;

  // Reflected CRC-32 update over one byte, one bit per step.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/log_frame_validator_top.sv
// Log frame validator: byte-wise frame parser, CRC-32 check and result queue.
module log_frame_validator_top
  import lfv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Input channel: one byte of the log body per item.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               is_data,
  input  logic               end_of_log,
  // Output channel: frame records and the final verdict.
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic [63:0]        seq_number,
  output logic [15:0]        event_type,
  output logic [15:0]        schema_version,
  output logic signed [63:0] time_ms,
  output logic [31:0]        payload_length,
  output logic [1:0]         verdict,
  output logic [63:0]        last_good_seq,
  output logic               final_item
);

  // The block walks the committed log body one byte per item, starting after
  // the file header. Each frame is a 28-byte little-endian header (length,
  // sequence, type, schema, timestamp, CRC) followed by its payload. A CRC-32
  // runs over header bytes 0..23 and the payload. When a frame completes, a
  // frame record with its header fields is queued; an item with end_of_log set
  // queues a verdict (ok, truncated, CRC mismatch or sequence gap) carrying the
  // last sequence number that validated, and then returns all state to reset
  // so a new log may follow. Only the first error is kept. The whole update
  // for one item (CRC byte step, field capture, frame checks) is done in the
  // cycle the item is accepted, so one item is taken every clock while the
  // input is ready. Results are registered into a four-entry queue whose head
  // drives the output; the input is ready while at least two queue entries are
  // free. An item that both closes a frame and ends the log produces two
  // results, which leave the queue one after the other. With the output
  // always ready the sustained rate is one item per cycle.

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  hdr_idx_t    header_index, header_index_next;
  logic        in_payload, in_payload_next;
  logic [31:0] length_field, length_field_next;
  logic [63:0] seq_field, seq_field_next;
  logic [31:0] type_schema_fields, type_schema_fields_next;
  logic [63:0] time_field, time_field_next;
  logic [31:0] stored_crc, stored_crc_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] payload_remaining, payload_remaining_next;
  logic [63:0] expected_seq, expected_seq_next;
  // Always expected_seq - 1: the last sequence number that validated.
  logic [63:0] last_good, last_good_next;
  verdict_t    latched_err, latched_err_next;

  // Result queue
  result_t              res_mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_CNT_W-1:0] count;

  logic       accept;
  logic       take_byte;
  logic       take_eol;
  logic       frame_done;
  logic [31:0] crc_final;
  verdict_t   final_verdict;
  result_t    rec_frame;
  result_t    rec_verdict;
  result_t    rec_a;
  result_t    rec_b;
  logic [1:0] n_push;
  logic       pop;
  result_t    head;

  assign accept    = in_valid && in_ready;
  assign take_byte = accept && is_data;
  assign take_eol  = accept && end_of_log;

  always_comb begin
    header_index_next       = header_index;
    in_payload_next         = in_payload;
    length_field_next       = length_field;
    seq_field_next          = seq_field;
    type_schema_fields_next = type_schema_fields;
    time_field_next         = time_field;
    stored_crc_next         = stored_crc;
    running_crc_next        = running_crc;
    payload_remaining_next  = payload_remaining;
    expected_seq_next       = expected_seq;
    last_good_next          = last_good;
    latched_err_next        = latched_err;
    frame_done              = 1'b0;
    final_verdict           = latched_err;

    if (take_byte) begin
      if (in_payload) begin
        running_crc_next       = crc_byte(running_crc, data_byte);
        payload_remaining_next = payload_remaining - 32'd1;
        frame_done             = (payload_remaining == 32'd1);
      end else begin
        if (header_index < hdr_idx_t'(CRC_SPAN)) begin
          running_crc_next = crc_byte(running_crc, data_byte);
        end
        if (header_index < hdr_idx_t'(LEN_BYTES)) begin
          length_field_next = {data_byte, length_field[31:8]};
        end else if (header_index < hdr_idx_t'(OFF_TYPE)) begin
          seq_field_next = {data_byte, seq_field[63:8]};
        end else if (header_index < hdr_idx_t'(OFF_TIME)) begin
          type_schema_fields_next = {data_byte, type_schema_fields[31:8]};
        end else if (header_index < hdr_idx_t'(CRC_SPAN)) begin
          time_field_next = {data_byte, time_field[63:8]};
        end else begin
          stored_crc_next = {data_byte, stored_crc[31:8]};
        end
        if (header_index == hdr_idx_t'(HDR_BYTES - 1)) begin
          header_index_next = '0;
          if (length_field_next == 32'd0) begin
            frame_done = 1'b1;
          end else begin
            in_payload_next        = 1'b1;
            payload_remaining_next = length_field_next;
          end
        end else begin
          header_index_next = header_index + hdr_idx_t'(1);
        end
      end
    end

    // The CRC seen at frame end is the one after this byte's update.
    crc_final = ~running_crc_next;

    if (frame_done) begin
      if (latched_err == VERDICT_OK) begin
        if (crc_final != stored_crc_next) begin
          latched_err_next = VERDICT_CRC;
        end else if (seq_field_next != expected_seq) begin
          latched_err_next = VERDICT_SEQ;
        end else begin
          expected_seq_next = expected_seq + 64'd1;
          last_good_next    = expected_seq;
        end
      end
      running_crc_next       = CRC_INIT;
      header_index_next      = '0;
      in_payload_next        = 1'b0;
      payload_remaining_next = '0;
    end

    // Frame record reflects the state after this frame's checks.
    rec_frame.kind           = KIND_FRAME;
    rec_frame.seq_number     = seq_field_next;
    rec_frame.event_type     = type_schema_fields_next[15:0];
    rec_frame.schema_version = type_schema_fields_next[31:16];
    rec_frame.time_ms        = time_field_next;
    rec_frame.payload_length = length_field_next;
    rec_frame.verdict        = latched_err_next;
    rec_frame.last_good_seq  = last_good_next;
    rec_frame.final_item     = !take_eol;

    // A partly received frame at the end marker is a truncation, unless an
    // earlier error is already latched.
    final_verdict = latched_err_next;
    if (latched_err_next == VERDICT_OK &&
        (header_index_next != '0 || in_payload_next)) begin
      final_verdict = VERDICT_TRUNC;
    end

    rec_verdict.kind           = KIND_VERDICT;
    rec_verdict.seq_number     = '0;
    rec_verdict.event_type     = '0;
    rec_verdict.schema_version = '0;
    rec_verdict.time_ms        = '0;
    rec_verdict.payload_length = '0;
    rec_verdict.verdict        = final_verdict;
    rec_verdict.last_good_seq  = last_good_next;
    rec_verdict.final_item     = 1'b1;

    if (take_eol) begin
      header_index_next       = '0;
      in_payload_next         = 1'b0;
      length_field_next       = '0;
      seq_field_next          = '0;
      type_schema_fields_next = '0;
      time_field_next         = '0;
      stored_crc_next         = '0;
      running_crc_next        = CRC_INIT;
      payload_remaining_next  = '0;
      expected_seq_next       = 64'd1;
      last_good_next          = '0;
      latched_err_next        = VERDICT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_index       <= '0;
      in_payload         <= 1'b0;
      length_field       <= '0;
      seq_field          <= '0;
      type_schema_fields <= '0;
      time_field         <= '0;
      stored_crc         <= '0;
      running_crc        <= CRC_INIT;
      payload_remaining  <= '0;
      expected_seq       <= 64'd1;
      last_good          <= '0;
      latched_err        <= VERDICT_OK;
    end else begin
      header_index       <= header_index_next;
      in_payload         <= in_payload_next;
      length_field       <= length_field_next;
      seq_field          <= seq_field_next;
      type_schema_fields <= type_schema_fields_next;
      time_field         <= time_field_next;
      stored_crc         <= stored_crc_next;
      running_crc        <= running_crc_next;
      payload_remaining  <= payload_remaining_next;
      expected_seq       <= expected_seq_next;
      last_good          <= last_good_next;
      latched_err        <= latched_err_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: up to two pushes and one pop per cycle.
  // ---------------------------------------------------------------------------
  assign rec_a  = frame_done ? rec_frame : rec_verdict;
  assign rec_b  = rec_verdict;
  assign n_push = {1'b0, frame_done} + {1'b0, take_eol};
  assign pop    = out_valid && out_ready;

  assign in_ready  = (count <= RES_CNT_W'(RES_DEPTH - 2));
  assign out_valid = (count != '0);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      res_mem[wr_ptr] <= rec_a;
    end
    if (n_push == 2'd2) begin
      res_mem[wr_ptr + RES_PTR_W'(1)] <= rec_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(n_push);
      rd_ptr <= rd_ptr + RES_PTR_W'(pop);
      count  <= count + RES_CNT_W'(n_push) - RES_CNT_W'(pop);
    end
  end

  assign head           = res_mem[rd_ptr];
  assign kind           = head.kind;
  assign seq_number     = head.seq_number;
  assign event_type     = head.event_type;
  assign schema_version = head.schema_version;
  assign time_ms        = head.time_ms;
  assign payload_length = head.payload_length;
  assign verdict        = head.verdict;
  assign last_good_seq  = head.last_good_seq;
  assign final_item     = head.final_item;

`ifndef NO_ASSERTIONS
  // The queue never holds more results than it has entries.
  assert property (@(posedge clk) disable iff (rst) count <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

  // The last good sequence number always trails the expected one by one.
  assert property (@(posedge clk) disable iff (rst) expected_seq == last_good + 64'd1)
    else $error("sequence tracking out of step");

  // A latched error holds until an end marker clears it.
  assert property (@(posedge clk) disable iff (rst)
    (latched_err != VERDICT_OK && !take_eol) |=> (latched_err == $past(latched_err)))
    else $error("latched error changed");

  // After an end marker the parser is back at the start of a frame.
  assert property (@(posedge clk) disable iff (rst)
    take_eol |=> (header_index == '0 && !in_payload && expected_seq == 64'd1 &&
                  running_crc == CRC_INIT))
    else $error("state not restored after end marker");
`endif

endmodule

FILE: verif/log_frame_validator_top_tb.sv
// Self-checking testbench for the log frame validator: framed byte logs against a local model.
module log_frame_validator_top_tb;
  import lfv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Run limits. A short settle time runs after the last owed result has been checked.
  // The cycle limit is many times the slowest run.
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 400000;
  // Longest payload the frame builder generates. Longer declared lengths are only
  // used for frames that get cut short.
  localparam int MAX_BODY      = 64;

  // Where the end marker goes when a frame is sent.
  typedef enum int {
    EOL_NONE,
    EOL_ON_LAST,
    EOL_BARE
  } eol_mode_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         data_byte = 8'h00;
  logic               is_data = 1'b0;
  logic               end_of_log = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               kind;
  logic [63:0]        seq_number;
  logic [15:0]        event_type;
  logic [15:0]        schema_version;
  logic signed [63:0] time_ms;
  logic [31:0]        payload_length;
  logic [1:0]         verdict;
  logic [63:0]        last_good_seq;
  logic               final_item;

  log_frame_validator_top uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .is_data        (is_data),
    .end_of_log     (end_of_log),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .seq_number     (seq_number),
    .event_type     (event_type),
    .schema_version (schema_version),
    .time_ms        (time_ms),
    .payload_length (payload_length),
    .verdict        (verdict),
    .last_good_seq  (last_good_seq),
    .final_item     (final_item)
  );

  // Idle percentages of the two sides; changed between phases.
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;

  int mismatches = 0;
  int items_sent = 0;
  int cycle_count = 0;

  // Records and verdicts the block still owes, oldest first.
  result_t expected_results[$];

  // Model state of the frame parser.
  logic [4:0]  hdr_pos;
  logic        in_body;
  logic [31:0] len_acc;
  logic [63:0] seq_acc;
  logic [31:0] type_schema_acc;
  logic [63:0] time_acc;
  logic [31:0] crc_rx;
  logic [31:0] crc_run;
  logic [31:0] body_left;
  logic [63:0] next_seq;
  verdict_t    err_latched;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Watchdog: a run that hangs, or that is left owing results, ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time,
               expected_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Reflected CRC-32, one bit per step, folding the polynomial in when bit 0 is set.
  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] acc;
    acc = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      acc = (acc >> 1) ^ (CRC_POLY & {32{acc[0]}});
    end
    return acc;
  endfunction

  // Appends one result to the list of results still owed.
  function automatic void queue_result(input result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void clear_state();
    hdr_pos         = '0;
    in_body         = 1'b0;
    len_acc         = '0;
    seq_acc         = '0;
    type_schema_acc = '0;
    time_acc        = '0;
    crc_rx          = '0;
    crc_run         = CRC_INIT;
    body_left       = '0;
    next_seq        = 64'd1;
    err_latched     = VERDICT_OK;
  endfunction

  // A frame is complete: check it unless an error is already latched, then queue its
  // record. The record carries the error state as it stands after this frame.
  function automatic void close_frame(input bit last);
    result_t r;
    if (err_latched == VERDICT_OK) begin
      if (~crc_run != crc_rx) begin
        err_latched = VERDICT_CRC;
      end else if (seq_acc != next_seq) begin
        err_latched = VERDICT_SEQ;
      end else begin
        next_seq = next_seq + 64'd1;
      end
    end
    r                = '0;
    r.kind           = KIND_FRAME;
    r.seq_number     = seq_acc;
    r.event_type     = type_schema_acc[15:0];
    r.schema_version = type_schema_acc[31:16];
    r.time_ms        = time_acc;
    r.payload_length = len_acc;
    r.verdict        = err_latched;
    r.last_good_seq  = next_seq - 64'd1;
    r.final_item     = last;
    queue_result(r);
    crc_run   = CRC_INIT;
    hdr_pos   = '0;
    in_body   = 1'b0;
    body_left = '0;
  endfunction

  // Works out what one accepted item makes the block produce.
  function automatic void predict_item(input logic [7:0] b, input logic d, input logic e);
    int         pos;
    result_t    r;
    if (d) begin
      if (in_body) begin
        crc_run   = crc32_step(crc_run, b);
        body_left = body_left - 32'd1;
        if (body_left == 32'd0) begin
          close_frame(!e);
        end
      end else begin
        pos = int'(hdr_pos);
        if (pos < CRC_SPAN) begin
          crc_run = crc32_step(crc_run, b);
        end
        // Little-endian fields: each new byte enters at the top and shifts down.
        if (pos < LEN_BYTES) begin
          len_acc = {b, len_acc[31:8]};
        end else if (pos < OFF_TYPE) begin
          seq_acc = {b, seq_acc[63:8]};
        end else if (pos < OFF_TIME) begin
          type_schema_acc = {b, type_schema_acc[31:8]};
        end else if (pos < CRC_SPAN) begin
          time_acc = {b, time_acc[63:8]};
        end else begin
          crc_rx = {b, crc_rx[31:8]};
        end
        if (pos == HDR_BYTES - 1) begin
          hdr_pos = '0;
          if (len_acc == 32'd0) begin
            close_frame(!e);
          end else begin
            in_body   = 1'b1;
            body_left = len_acc;
          end
        end else begin
          hdr_pos = 5'(pos + 1);
        end
      end
    end
    if (e) begin
      // A frame left open at the end marker is a truncation, unless an earlier
      // error already holds the verdict.
      if (err_latched == VERDICT_OK && (hdr_pos != '0 || in_body)) begin
        err_latched = VERDICT_TRUNC;
      end
      r               = '0;
      r.kind          = KIND_VERDICT;
      r.verdict       = err_latched;
      r.last_good_seq = next_seq - 64'd1;
      r.final_item    = 1'b1;
      queue_result(r);
      clear_state();
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  // Monitor and checker. Both handshakes are sampled at the same edge, and the input
  // side is modeled first so that a result can never be checked before its cause.
  always @(posedge clk) begin : check_proc
    result_t want;
    if (!rst && in_valid && in_ready === 1'b1) begin
      predict_item(data_byte, is_data, end_of_log);
    end
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with none expected, expected nothing, actual kind %0b seq %0h",
                 $time, kind, seq_number);
      end else begin
        want = expected_results.pop_front();
        if (kind !== want.kind) report_mismatch("kind", 64'(want.kind), 64'(kind));
        if (seq_number !== want.seq_number)
          report_mismatch("seq_number", want.seq_number, seq_number);
        if (event_type !== want.event_type)
          report_mismatch("event_type", 64'(want.event_type), 64'(event_type));
        if (schema_version !== want.schema_version)
          report_mismatch("schema_version", 64'(want.schema_version), 64'(schema_version));
        if (time_ms !== want.time_ms) report_mismatch("time_ms", want.time_ms, time_ms);
        if (payload_length !== want.payload_length)
          report_mismatch("payload_length", 64'(want.payload_length), 64'(payload_length));
        if (verdict !== want.verdict)
          report_mismatch("verdict", 64'(want.verdict), 64'(verdict));
        if (last_good_seq !== want.last_good_seq)
          report_mismatch("last_good_seq", want.last_good_seq, last_good_seq);
        if (final_item !== want.final_item)
          report_mismatch("final_item", 64'(want.final_item), 64'(final_item));
      end
    end
  end

  // Sends one item and returns at the edge where it is taken. Before the item the
  // sender may idle for a random gap; valid is lowered only for such a gap.
  task automatic send_item(input logic [7:0] b, input logic d, input logic e);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    is_data    <= d;
    end_of_log <= e;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (d || e) items_sent++;
  endtask

  // Builds a frame with a correct CRC (or a deliberately broken one), then sends the
  // first keep bytes of it (all when keep is negative) and the end marker as asked.
  task automatic send_frame(input logic [63:0] seq, input logic [15:0] typ,
                            input logic [15:0] sch, input logic [63:0] tms,
                            input logic [31:0] len, input bit bad_crc,
                            input int keep, input eol_mode_t eol);
    logic [7:0]  hdr[$];
    logic [7:0]  body[$];
    logic [31:0] c;
    logic [7:0]  pb;
    int          pay_n;
    int          total;
    for (int k = 0; k < 4; k++) hdr.insert(hdr.size(), len[8*k +: 8]);
    for (int k = 0; k < 8; k++) hdr.insert(hdr.size(), seq[8*k +: 8]);
    for (int k = 0; k < 2; k++) hdr.insert(hdr.size(), typ[8*k +: 8]);
    for (int k = 0; k < 2; k++) hdr.insert(hdr.size(), sch[8*k +: 8]);
    for (int k = 0; k < 8; k++) hdr.insert(hdr.size(), tms[8*k +: 8]);
    c = CRC_INIT;
    foreach (hdr[k]) c = crc32_step(c, hdr[k]);
    pay_n = (len > MAX_BODY) ? MAX_BODY : int'(len);
    for (int k = 0; k < pay_n; k++) begin
      pb = 8'($urandom);
      body.insert(body.size(), pb);
      c = crc32_step(c, pb);
    end
    c = ~c;
    if (bad_crc) c = c ^ (32'd1 << $urandom_range(31));
    for (int k = 0; k < 4; k++) hdr.insert(hdr.size(), c[8*k +: 8]);
    foreach (body[k]) hdr.insert(hdr.size(), body[k]);
    total = (keep < 0 || keep > hdr.size()) ? hdr.size() : keep;
    for (int k = 0; k < total; k++) begin
      send_item(hdr[k], 1'b1, (eol == EOL_ON_LAST) && (k == total - 1));
    end
    if (eol == EOL_BARE) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // The sender holds off until the block has delivered everything it owes.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle(input int src_pct, input int sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
  endtask

  // Idle items change nothing; an end marker on an empty log gives an ok verdict.
  task automatic test_empty_and_idle();
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1);
  endtask

  // Frames with no payload complete on their last header byte. The second one also
  // carries the end marker, so one item yields a record and then the verdict.
  task automatic test_zero_length_frames();
    send_frame(64'd1, 16'hFFFF, 16'h0000, 64'h8000_0000_0000_0000, 32'd0, 1'b0, -1,
               EOL_NONE);
    send_frame(64'd2, 16'h0000, 16'hFFFF, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, -1,
               EOL_ON_LAST);
  endtask

  // Field extremes, short payloads, and a frame declaring the largest length that
  // is cut off by the end marker.
  task automatic test_field_extremes();
    send_frame(64'd1, 16'h0000, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 1'b0, -1,
               EOL_NONE);
    send_frame(64'd2, 16'h8000, 16'h0001, 64'd0, 32'd3, 1'b0, -1, EOL_ON_LAST);
    send_frame(64'd1, 16'h1234, 16'h0000, 64'd0, 32'hFFFF_FFFF, 1'b0, HDR_BYTES + 3,
               EOL_ON_LAST);
  endtask

  // A bad CRC together with a wrong sequence number reports the CRC. The error
  // latches: later good frames are still reported but no longer advance the count.
  task automatic test_crc_error_latch();
    send_frame(64'd1, 16'h0001, 16'h0001, 64'd100, 32'd2, 1'b0, -1, EOL_NONE);
    send_frame(64'd5, 16'h0002, 16'h0001, 64'd200, 32'd4, 1'b1, -1, EOL_NONE);
    send_frame(64'd2, 16'h0003, 16'h0001, 64'd300, 32'd0, 1'b0, -1, EOL_NONE);
    send_frame(64'd3, 16'h0004, 16'h0001, 64'd400, 32'd1, 1'b0, HDR_BYTES - 4,
               EOL_BARE);
  endtask

  // Sequence gaps: a log starting at zero, and a jump to the largest number followed
  // by a cut-off frame, where the gap and not the truncation is reported.
  task automatic test_sequence_gap();
    send_frame(64'd0, 16'h0010, 16'h0002, 64'd1, 32'd1, 1'b0, -1, EOL_BARE);
    send_frame(64'd1, 16'h0011, 16'h0002, 64'd2, 32'd0, 1'b0, -1, EOL_NONE);
    send_frame(64'hFFFF_FFFF_FFFF_FFFF, 16'h0012, 16'h0002, 64'd3, 32'd2, 1'b0, -1,
               EOL_NONE);
    send_frame(64'd3, 16'h0013, 16'h0002, 64'd4, 32'd0, 1'b0, 10, EOL_ON_LAST);
  endtask

  // Truncation inside a payload and inside a header.
  task automatic test_truncation();
    send_frame(64'd1, 16'h0020, 16'h0003, 64'd7, 32'd0, 1'b0, -1, EOL_NONE);
    send_frame(64'd2, 16'h0021, 16'h0003, 64'd8, 32'd6, 1'b0, HDR_BYTES + 2,
               EOL_ON_LAST);
    send_frame(64'd1, 16'h0022, 16'h0003, 64'd9, 32'd0, 1'b0, 5, EOL_BARE);
  endtask

  // Random logs of a few frames each. Most are well formed with random content; some
  // carry a bad CRC, a skipped or wild sequence number, a cut-off last frame, idle
  // items, or stray bytes that throw the framing off.
  task automatic test_random_logs(input int n_items);
    int          start;
    int          n_frames;
    int          r;
    int          keep;
    logic [63:0] seq;
    logic [63:0] seq_use;
    logic [31:0] len;
    logic [15:0] typ;
    logic [15:0] sch;
    logic [63:0] tms;
    eol_mode_t   eol;
    start = items_sent;
    while (items_sent - start < n_items) begin
      n_frames = $urandom_range(1, 6);
      seq = 64'd1;
      for (int f = 0; f < n_frames; f++) begin
        if ($urandom_range(99) < 8) begin
          repeat ($urandom_range(1, 2)) send_item(8'($urandom), 1'b0, 1'b0);
        end
        if ($urandom_range(99) < 4) begin
          repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b1, 1'b0);
        end
        r = $urandom_range(99);
        if (r < 15) begin
          len = 32'd0;
        end else if (r < 85) begin
          len = $urandom_range(1, 12);
        end else begin
          len = $urandom_range(13, 40);
        end
        typ = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
        sch = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
        tms = ($urandom_range(19) == 0) ? 64'h8000_0000_0000_0000 : {$urandom, $urandom};
        r = $urandom_range(99);
        seq_use = seq;
        if (r >= 8 && r < 12) begin
          seq_use = seq + 64'($urandom_range(1, 3));
        end else if (r >= 12 && r < 14) begin
          seq_use = {$urandom, $urandom};
        end
        keep = -1;
        eol = EOL_NONE;
        if (f == n_frames - 1) begin
          eol = $urandom_range(1) ? EOL_ON_LAST : EOL_BARE;
          if ($urandom_range(99) < 12) keep = $urandom_range(1, HDR_BYTES - 1 + int'(len));
        end
        send_frame(seq_use, typ, sch, tms, len, r < 8, keep, eol);
        seq = seq + 64'd1;
      end
    end
  endtask

  initial begin
    clear_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed checks with a slow receiver.
    set_idle(24, 56);
    test_empty_and_idle();
    test_zero_length_frames();
    test_field_extremes();
    test_crc_error_latch();
    test_sequence_gap();
    test_truncation();
    wait_for_results();

    // Random logs: slow receiver, then slow sender, then full rate on both sides.
    test_random_logs(450);
    wait_for_results();
    set_idle(56, 24);
    test_random_logs(450);
    wait_for_results();
    set_idle(0, 0);
    test_random_logs(450);
    wait_for_results();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
